@@ hw/rtl/nalepb_pkg.sv @@
package nalepb_pkg;

    localparam int BYTE_W = 8;
    localparam int HELD_W = 6;
    localparam int HL_W   = 2;
    localparam int RUN_W  = 2;

    localparam logic [1:0] PH_SCAN   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;

    localparam logic [BYTE_W-1:0] EPB_BYTE = 8'h03;
    localparam logic [BYTE_W-1:0] SC_BYTE  = 8'h01;

    localparam logic [RUN_W-1:0]  RUN_SAT  = 2'd2;
    localparam logic [HL_W-1:0]   HL_ONE   = 2'd1;
    localparam logic [HELD_W-1:0] HELD_ONE = 6'd1;
    localparam logic [HELD_W-1:0] HELD_SC  = 6'd2;

    typedef struct packed {
        logic [1:0]       phase;
        logic [HL_W-1:0]  header_left;
        logic [RUN_W-1:0] zero_run;
    } feed_state_t;

endpackage

@@ hw/rtl/nalepb_feed.sv @@
module nalepb_feed
(
    input  nalepb_pkg::feed_state_t cur,
    input  logic [7:0]              data_byte,
    output logic                    emit,
    output nalepb_pkg::feed_state_t nxt
);
    import nalepb_pkg::*;

    always_comb
    begin
        nxt  = cur;
        emit = 1'b1;
        if (cur.phase == PH_HEADER)
        begin
            if (cur.header_left != '0)
            begin
                nxt.header_left = cur.header_left - HL_ONE;
            end
            if (cur.header_left <= HL_ONE)
            begin
                nxt.phase    = PH_BODY;
                nxt.zero_run = '0;
            end
        end
        else if (cur.zero_run >= RUN_SAT && data_byte == EPB_BYTE)
        begin
            // An emulation prevention byte after two zeros is removed.
            emit         = 1'b0;
            nxt.zero_run = '0;
        end
        else if (data_byte == '0)
        begin
            if (cur.zero_run < RUN_SAT)
            begin
                nxt.zero_run = cur.zero_run + 1'b1;
            end
        end
        else
        begin
            nxt.zero_run = '0;
        end
    end

endmodule

@@ hw/rtl/nal_unit_epb_removal.sv @@
// Emulation prevention byte removal for one NAL unit at a time.
// The slave channel takes one byte per transaction in s_tdata, with s_tlast on
// the final byte of the unit. The master channel gives one byte per transaction
// in m_tdata; m_tuser[0] says whether a byte is present (clear for a bare end
// mark), m_tuser[1] reports that the leading zero count saturated, and m_tlast
// marks the last transaction of the unit.
// Each accepted byte is held in an input register and processed there. The
// result is registered in the output register, which drives m_tvalid. A new byte
// can be taken every cycle while the output is not stalled and no held zeros are
// being released. Leading zeros are held back in a counter. Releasing them takes
// a set-up step and then a step for each zero. A byte that ends the leading scan
// with held zeros therefore occupies the input register for the set-up step, the
// zero steps and its own step. A final byte that yields nothing ends on the last
// zero step instead, and so does a final zero byte that leaves zeros held.
// Reset clears the unit state, the input register and the output register.
// When m_tready is low the output register holds its transaction, the input
// register stops, and s_tready falls once the input register is full.
module nal_unit_epb_removal
#(
    parameter int HEADER_BYTES   = 2,
    parameter int MAX_HELD_ZEROS = 63
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] byte_present, [1] zero_overflow
    output logic       m_tlast
);
    import nalepb_pkg::*;

    localparam logic [HL_W-1:0]   HEADER_INIT = HL_W'(HEADER_BYTES);
    localparam logic [HELD_W-1:0] HELD_MAX    = HELD_W'(MAX_HELD_ZEROS);

    feed_state_t feed_reg, feed_next;
    feed_state_t feed_in_state, feed_out;
    logic        feed_emit;
    logic [7:0]  feed_in_byte;

    logic [HELD_W-1:0] held_reg, held_next;
    logic              ovf_reg, ovf_next;

    logic              pend_valid_reg;
    logic [7:0]        pend_byte_reg;
    logic              pend_last_reg;
    logic              pend_started_reg, started_next;
    logic [HELD_W-1:0] pend_flush_reg, flush_next;
    logic              pend_tail_reg, tail_next;

    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       out_present_reg;
    logic       out_end_reg;
    logic       out_ovf_reg;

    logic       slot_free, step_go, step_done, use_feed;
    logic       res_valid, res_present, res_end;
    logic [7:0] res_byte;
    logic       in_take;
    logic       tail_drop;

    nalepb_feed u_feed
    (
        .cur       (feed_in_state),
        .data_byte (feed_in_byte),
        .emit      (feed_emit),
        .nxt       (feed_out)
    );

    always_comb
    begin
        slot_free     = !out_valid_reg || m_tready;
        step_go       = pend_valid_reg && slot_free;
        feed_in_state = feed_reg;
        feed_in_byte  = pend_byte_reg;
        use_feed      = 1'b0;
        step_done     = 1'b0;
        tail_drop     = 1'b0;
        feed_next     = feed_reg;
        held_next     = held_reg;
        ovf_next      = ovf_reg;
        started_next  = pend_started_reg;
        flush_next    = pend_flush_reg;
        tail_next     = pend_tail_reg;

        if (!pend_started_reg)
        begin
            if (feed_reg.phase == PH_SCAN)
            begin
                if (pend_byte_reg == '0)
                begin
                    if (held_reg < HELD_MAX)
                    begin
                        held_next = held_reg + HELD_ONE;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (pend_last_reg)
                    begin
                        started_next = 1'b1;
                        flush_next   = held_next;
                        tail_next    = 1'b0;
                    end
                    else
                    begin
                        step_done = 1'b1;
                    end
                end
                else if (pend_byte_reg == SC_BYTE && held_reg >= HELD_SC)
                begin
                    // Start code: the held zeros and the 0x01 are dropped.
                    held_next = '0;
                    feed_next = '{phase: PH_HEADER, header_left: HEADER_INIT,
                                  zero_run: '0};
                    step_done = 1'b1;
                end
                else if (held_reg == '0)
                begin
                    feed_in_state = '{phase: PH_HEADER, header_left: HEADER_INIT,
                                      zero_run: feed_reg.zero_run};
                    use_feed      = 1'b1;
                    step_done     = 1'b1;
                end
                else
                begin
                    // Release the held zeros first; this byte follows them.
                    feed_next    = '{phase: PH_HEADER, header_left: HEADER_INIT,
                                     zero_run: feed_reg.zero_run};
                    held_next    = '0;
                    started_next = 1'b1;
                    flush_next   = held_reg;
                    tail_next    = 1'b1;
                end
            end
            else
            begin
                use_feed  = 1'b1;
                step_done = 1'b1;
            end
        end
        else if (pend_flush_reg != '0)
        begin
            feed_in_byte = '0;
            use_feed     = 1'b1;
            flush_next   = pend_flush_reg - HELD_ONE;
            // A final byte that would be removed after the released zeros ends the
            // unit on the last released zero instead.
            tail_drop    = pend_tail_reg && pend_last_reg && feed_out.phase != PH_HEADER &&
                           feed_out.zero_run >= RUN_SAT && pend_byte_reg == EPB_BYTE;
            step_done    = (pend_flush_reg == HELD_ONE) && (!pend_tail_reg || tail_drop);
        end
        else
        begin
            use_feed  = 1'b1;
            step_done = 1'b1;
        end

        if (use_feed)
        begin
            feed_next = feed_out;
        end

        res_present = use_feed && feed_emit;
        res_end     = step_done && pend_last_reg;
        res_valid   = res_present || res_end;
        res_byte    = res_present ? feed_in_byte : '0;

        if (res_end)
        begin
            feed_next = '{phase: PH_SCAN, header_left: HEADER_INIT, zero_run: '0};
            held_next = '0;
            ovf_next  = 1'b0;
        end
    end

    assign s_tready = !pend_valid_reg || (step_go && step_done);
    assign in_take  = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            feed_reg         <= '{phase: PH_SCAN, header_left: HEADER_INIT, zero_run: '0};
            held_reg         <= '0;
            ovf_reg          <= 1'b0;
            pend_valid_reg   <= 1'b0;
            pend_started_reg <= 1'b0;
            pend_flush_reg   <= '0;
            pend_tail_reg    <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (step_go)
            begin
                feed_reg <= feed_next;
                held_reg <= held_next;
                ovf_reg  <= ovf_next;
            end
            if (in_take)
            begin
                pend_valid_reg   <= 1'b1;
                pend_started_reg <= 1'b0;
                pend_flush_reg   <= '0;
                pend_tail_reg    <= 1'b0;
            end
            else if (step_go)
            begin
                pend_valid_reg   <= !step_done;
                pend_started_reg <= started_next;
                pend_flush_reg   <= flush_next;
                pend_tail_reg    <= tail_next;
            end
            if (slot_free)
            begin
                out_valid_reg <= step_go && res_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            pend_byte_reg <= s_tdata;
            pend_last_reg <= s_tlast;
        end
        if (step_go && res_valid)
        begin
            out_byte_reg    <= res_byte;
            out_present_reg <= res_present;
            out_end_reg     <= res_end;
            out_ovf_reg     <= ovf_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = {out_ovf_reg, out_present_reg};
    assign m_tlast  = out_end_reg;

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 1ps

module tb;

    import nalepb_pkg::*;

    localparam int HDR_BYTES      = 2;
    localparam int MAX_HELD       = 63;
    localparam int MAX_RESULTS    = 64;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 20;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              present;
        logic              unit_end;
        logic              overflow;
    } epb_result_t;

    logic       clk;
    logic       rst_n;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;    // [7:0] data_byte
    logic       s_tlast;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;    // [7:0] out_byte
    logic [1:0] m_tuser;    // [0] byte_present, [1] zero_overflow
    logic       m_tlast;

    // Predicted unit state.
    logic [1:0]       unit_phase;
    int               held_zeros;
    logic [HL_W-1:0]  hdr_left;
    logic [RUN_W-1:0] zero_run;
    logic             ovf_seen;

    epb_result_t step_q[$];
    epb_result_t expected_q[$];
    logic [7:0]  unit_buf[$];

    int fail_count;
    bit tx_idle;
    bit rx_idle;

    nal_unit_epb_removal
    #(
        .HEADER_BYTES   (HDR_BYTES),
        .MAX_HELD_ZEROS (MAX_HELD)
    )
    dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int draw_wait(input bit idle_on);
        if (!idle_on || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    function automatic logic [7:0] pick_stream_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4)
            return 8'h00;
        else if (r < 6)
            return EPB_BYTE;
        else if (r == 6)
            return SC_BYTE;
        return 8'($urandom_range(0, 255));
    endfunction

    // ---------------------------------------------------------------- predictor

    function automatic void clear_unit_state();
        unit_phase = PH_SCAN;
        held_zeros = 0;
        hdr_left   = HL_W'(HDR_BYTES % 4);
        zero_run   = '0;
        ovf_seen   = 1'b0;
    endfunction

    function automatic void put_result(input logic [7:0] b, input logic present);
        epb_result_t r;
        if (step_q.size() >= MAX_RESULTS)
            return;
        r.out_byte = b;
        r.present  = present;
        r.unit_end = 1'b0;
        r.overflow = ovf_seen;
        step_q.push_back(r);
    endfunction

    function automatic void enter_header();
        unit_phase = PH_HEADER;
        hdr_left   = HL_W'(HDR_BYTES % 4);
        if (hdr_left == '0)
            unit_phase = PH_BODY;
    endfunction

    function automatic void feed_byte(input logic [7:0] b);
        if (unit_phase == PH_HEADER)
        begin
            put_result(b, 1'b1);
            if (hdr_left != '0)
                hdr_left = hdr_left - HL_ONE;
            if (hdr_left == '0)
            begin
                unit_phase = PH_BODY;
                zero_run   = '0;
            end
            return;
        end
        // Any other phase code, the unused one included, runs the body logic.
        if (zero_run >= RUN_SAT && b == EPB_BYTE)
        begin
            zero_run = '0;
            return;
        end
        put_result(b, 1'b1);
        if (b == 8'h00)
            zero_run = (zero_run < RUN_SAT) ? zero_run + 1'b1 : RUN_SAT;
        else
            zero_run = '0;
    endfunction

    function automatic void release_held_zeros();
        int n;
        enter_header();
        n = held_zeros;
        for (int k = 0; k < n; k++)
            feed_byte(8'h00);
        held_zeros = 0;
    endfunction

    function automatic void predict_unit_byte(input logic [7:0] b, input logic is_last);
        step_q.delete();
        if (unit_phase == PH_SCAN)
        begin
            if (b == 8'h00)
            begin
                if (held_zeros < MAX_HELD)
                    held_zeros++;
                else
                    ovf_seen = 1'b1;
                if (is_last)
                    release_held_zeros();
            end
            else if (b == SC_BYTE && held_zeros >= int'(HELD_SC))
            begin
                held_zeros = 0;
                enter_header();
                zero_run = '0;
            end
            else
            begin
                release_held_zeros();
                feed_byte(b);
            end
        end
        else
        begin
            feed_byte(b);
        end

        if (is_last)
        begin
            // A final byte that yields nothing still closes the unit with a bare end mark.
            if (step_q.size() == 0)
                put_result(8'h00, 1'b0);
            step_q[step_q.size() - 1].unit_end = 1'b1;
            clear_unit_state();
        end
        foreach (step_q[i])
            expected_q.push_back(step_q[i]);
    endfunction

    // ---------------------------------------------------------------- driving

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        int gap;
        gap = draw_wait(tx_idle);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_tready);
        predict_unit_byte(b, is_last);
    endtask

    task automatic send_unit();
        foreach (unit_buf[i])
            send_byte(unit_buf[i], i == unit_buf.size() - 1);
    endtask

    // Builds one unit: leading zeros, then usually a start code or a byte that ends the
    // scan, a header and a body rich in zeros and prevention bytes.
    task automatic build_unit(input int lead_lo, input int lead_hi);
        int kind;
        int n_zero;
        int n_hdr;
        int n_body;
        unit_buf.delete();
        kind   = $urandom_range(0, 9);
        n_zero = $urandom_range(lead_lo, lead_hi);
        repeat (n_zero) unit_buf.push_back(8'h00);
        if (kind == 9)
        begin
            if ($urandom_range(0, 1) == 1)
                unit_buf.push_back(SC_BYTE);
        end
        else
        begin
            if (kind < 7)
                unit_buf.push_back(SC_BYTE);
            else
                unit_buf.push_back(8'($urandom_range(0, 255)));
            n_hdr = ($urandom_range(0, 4) == 0) ? $urandom_range(0, HDR_BYTES + 1) : HDR_BYTES;
            repeat (n_hdr)
                unit_buf.push_back(($urandom_range(0, 2) == 0) ? pick_stream_byte()
                                                               : 8'($urandom_range(0, 255)));
            n_body = $urandom_range(0, 14);
            repeat (n_body) unit_buf.push_back(pick_stream_byte());
        end
        if (unit_buf.size() == 0)
            unit_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t ns mismatch, %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    initial
    begin
        epb_result_t want;
        int stall_left;
        m_tready   = 1'b0;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("transaction with nothing expected", m_tdata, 0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (m_tdata !== want.out_byte)
                        report_mismatch("out_byte", m_tdata, want.out_byte);
                    if (m_tuser[0] !== want.present)
                        report_mismatch("byte_present", m_tuser[0], want.present);
                    if (m_tlast !== want.unit_end)
                        report_mismatch("unit_end", m_tlast, want.unit_end);
                    if (m_tuser[1] !== want.overflow)
                        report_mismatch("zero_overflow", m_tuser[1], want.overflow);
                end
                stall_left = draw_wait(rx_idle);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("%0t ns no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // ---------------------------------------------------------------- tests

    task automatic test_start_code_and_epb();
        tx_idle  = 1'b0;
        rx_idle  = 1'b0;
        unit_buf = '{8'h00, 8'h00, SC_BYTE, 8'h40, 8'h01, 8'h00, 8'h00, EPB_BYTE, 8'hFF};
        send_unit();
    endtask

    // A single zero before 0x01 is data; the prevention byte at the end leaves a bare end mark.
    task automatic test_short_start_code();
        tx_idle  = 1'b1;
        rx_idle  = 1'b1;
        unit_buf = '{8'h00, SC_BYTE, 8'h26, 8'h00, 8'h00, EPB_BYTE};
        send_unit();
    endtask

    task automatic test_units_ending_in_scan();
        unit_buf = '{8'h00, 8'h00, SC_BYTE};
        send_unit();
        unit_buf = '{8'h00, 8'h00, 8'h00};
        send_unit();
        unit_buf = '{8'hFF};
        send_unit();
    endtask

    task automatic test_zero_saturation();
        repeat (2)
        begin
            tx_idle = $urandom_range(0, 1);
            rx_idle = $urandom_range(0, 1);
            build_unit(MAX_HELD + 1, MAX_HELD + 7);
            send_unit();
        end
    endtask

    task automatic test_random_units(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items)
        begin
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 19) == 0)
                build_unit(0, MAX_HELD + 2);
            else
                build_unit(0, 4);
            send_unit();
            sent += unit_buf.size();
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 8'h00;
        s_tlast    = 1'b0;
        fail_count = 0;
        tx_idle    = 1'b0;
        rx_idle    = 1'b0;
        clear_unit_state();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_start_code_and_epb();
        test_short_start_code();
        test_units_ending_in_scan();
        test_zero_saturation();
        test_random_units(200);

        s_tvalid <= 1'b0;
        rx_idle = 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
